// File: rtl/sadc_pkg.sv
// ----------------------------------------------------------------------------
// sadc_pkg
// Shared widths, register indexes and constants for the serial converter
// read sequencer.
// ----------------------------------------------------------------------------
package sadc_pkg;

  localparam int DATA_BITS   = 8;
  localparam int TIMER_W     = 16;
  localparam int BIT_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [DATA_BITS-1:0]   data_t;

  localparam cfg_index_t CFG_HALF_PERIOD  = 2'd0;
  localparam cfg_index_t CFG_SINGLE_ENDED = 2'd1;
  localparam cfg_index_t CFG_ODD_SELECT   = 2'd2;

  localparam logic [TIMER_W-1:0] HALF_PERIOD_RESET = 16'd2;

endpackage

// File: rtl/sadc_if.sv
// ----------------------------------------------------------------------------
// sadc_tick_if / sadc_report_if
// Valid/ready channels: one tick of pin samples in, one report of pin levels
// and conversion status out.
// ----------------------------------------------------------------------------
interface sadc_tick_if;
  logic valid;
  logic ready;
  logic start_req;
  logic dio_in;

  modport source (output valid, output start_req, output dio_in, input ready);
  modport sink (input valid, input start_req, input dio_in, output ready);
endinterface

interface sadc_report_if;
  logic       valid;
  logic       ready;
  logic       chip_select_n;
  logic       serial_clock;
  logic       dio_out;
  logic       dio_drive;
  logic       result_valid;
  logic [7:0] result;
  logic       mismatch;

  modport source (output valid, output chip_select_n, output serial_clock,
                  output dio_out, output dio_drive, output result_valid,
                  output result, output mismatch, input ready);
  modport sink (input valid, input chip_select_n, input serial_clock,
                input dio_out, input dio_drive, input result_valid,
                input result, input mismatch, output ready);
endinterface

// File: rtl/serial_adc_read_sequencer_top.sv
// ----------------------------------------------------------------------------
// serial_adc_read_sequencer_top
// Read sequencer for a two-channel 8-bit serial converter with a shared
// data pin.
//
// Usage: every transfer on the tick channel is one tick of the sequencer,
// carrying a start request and the sampled data pin. Every tick gives one
// transfer on the report channel: chip select, serial clock, data pin drive
// and, on the closing tick of a conversion, the byte and a mismatch flag.
// Pin levels shown are those held before the tick is applied.
// The report is registered and shows in the cycle after its tick transfer.
// Throughput: one tick per cycle, set by the single output register; a tick is
// taken whenever that register is empty or being drained in the same cycle.
// Configuration: half period in ticks, mode bit and channel bit, written
// through cfg_we/cfg_index/cfg_data while idle.
// Reset: sequencer idle, no report pending, registers at half period 2,
// single-ended, channel 0.
// Receiver stall: the report is held and the tick channel drops ready until
// it is taken.
// ----------------------------------------------------------------------------
module serial_adc_read_sequencer_top (
  input  logic                           clk,
  input  logic                           rst,
  sadc_tick_if.sink                      tick,
  sadc_report_if.source                  report,
  input  logic                           cfg_we,
  input  sadc_pkg::cfg_index_t           cfg_index,
  input  logic [sadc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sadc_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_START_LO = 5'd1,
    PH_START_HI = 5'd2,
    PH_MODE_LO  = 5'd3,
    PH_MODE_HI  = 5'd4,
    PH_SEL_LO   = 5'd5,
    PH_SEL_HI   = 5'd6,
    PH_SETTLE   = 5'd7,
    PH_MSB_HI   = 5'd8,
    PH_MSB_LO   = 5'd9,
    PH_LSB_HI   = 5'd10,
    PH_LSB_LO   = 5'd11
  } phase_t;

  logic [TIMER_W-1:0]   half_period_ticks;
  logic                 single_ended;
  logic                 odd_select;

  phase_t               phase, phase_next;
  logic [TIMER_W-1:0]   tick_timer, tick_timer_next;
  data_t                msb_copy, msb_copy_next;
  data_t                lsb_copy, lsb_copy_next;
  logic [BIT_IDX_W-1:0] bit_index, bit_index_next;
  logic                 clock_level, clock_level_next;

  logic                 out_valid;
  logic                 accept;
  logic [TIMER_W-1:0]   half_eff;
  logic [TIMER_W:0]     timer_inc;
  logic                 slot_end;
  logic                 last_bit;
  logic [BIT_IDX_W-1:0] bit_index_inc;
  logic                 cs_n_now, drive_now, dio_now;
  logic                 fin, mis;

  assign accept     = tick.valid && tick.ready;
  assign tick.ready = !out_valid || report.ready;
  assign report.valid = out_valid;

  assign half_eff      = (half_period_ticks == '0) ? TIMER_W'(1) : half_period_ticks;
  assign timer_inc     = {1'b0, tick_timer} + (TIMER_W+1)'(1);
  assign slot_end      = timer_inc >= {1'b0, half_eff};
  assign last_bit      = bit_index >= BIT_IDX_W'(DATA_BITS - 1);
  assign bit_index_inc = bit_index + BIT_IDX_W'(1);

  always_comb begin
    cs_n_now  = (phase == PH_IDLE);
    drive_now = (phase >= PH_START_LO) && (phase <= PH_SEL_HI);
    case (phase)
      PH_START_LO, PH_START_HI: dio_now = 1'b1;
      PH_MODE_LO, PH_MODE_HI:   dio_now = single_ended;
      PH_SEL_LO, PH_SEL_HI:     dio_now = odd_select;
      default:                  dio_now = 1'b0;
    endcase
  end

  always_comb begin
    phase_next      = phase;
    tick_timer_next = tick_timer;
    msb_copy_next   = msb_copy;
    lsb_copy_next   = lsb_copy;
    bit_index_next  = bit_index;
    fin             = 1'b0;
    mis             = 1'b0;
    if (phase == PH_IDLE) begin
      if (tick.start_req) begin
        phase_next      = PH_START_LO;
        tick_timer_next = '0;
        msb_copy_next   = '0;
        lsb_copy_next   = '0;
        bit_index_next  = '0;
      end
    end else if (!slot_end) begin
      tick_timer_next = timer_inc[TIMER_W-1:0];
    end else begin
      tick_timer_next = '0;
      unique case (phase)
        PH_START_LO: phase_next = PH_START_HI;
        PH_START_HI: phase_next = PH_MODE_LO;
        PH_MODE_LO:  phase_next = PH_MODE_HI;
        PH_MODE_HI:  phase_next = PH_SEL_LO;
        PH_SEL_LO:   phase_next = PH_SEL_HI;
        PH_SEL_HI:   phase_next = PH_SETTLE;
        PH_SETTLE:   phase_next = PH_MSB_HI;
        PH_MSB_HI:   phase_next = PH_MSB_LO;
        PH_LSB_HI:   phase_next = PH_LSB_LO;
        PH_MSB_LO: begin
          msb_copy_next = {msb_copy[DATA_BITS-2:0], tick.dio_in};
          if (last_bit) begin
            lsb_copy_next  = data_t'(tick.dio_in);
            bit_index_next = '0;
            phase_next     = PH_LSB_HI;
          end else begin
            bit_index_next = bit_index_inc;
            phase_next     = PH_MSB_HI;
          end
        end
        PH_LSB_LO: begin
          if (last_bit) begin
            fin            = 1'b1;
            mis            = (msb_copy != lsb_copy);
            bit_index_next = '0;
            phase_next     = PH_IDLE;
          end else begin
            bit_index_next = bit_index_inc;
            lsb_copy_next  = lsb_copy | (data_t'(tick.dio_in) << bit_index_inc[2:0]);
            phase_next     = PH_LSB_HI;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
    clock_level_next = (phase_next == PH_START_HI) || (phase_next == PH_MODE_HI) ||
                       (phase_next == PH_SEL_HI) || (phase_next == PH_MSB_HI) ||
                       (phase_next == PH_LSB_HI);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= HALF_PERIOD_RESET;
      single_ended      <= 1'b1;
      odd_select        <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HALF_PERIOD:  half_period_ticks <= cfg_data[TIMER_W-1:0];
        CFG_SINGLE_ENDED: single_ended      <= cfg_data[0];
        CFG_ODD_SELECT:   odd_select        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      tick_timer  <= '0;
      msb_copy    <= '0;
      lsb_copy    <= '0;
      bit_index   <= '0;
      clock_level <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        phase       <= phase_next;
        tick_timer  <= tick_timer_next;
        msb_copy    <= msb_copy_next;
        lsb_copy    <= lsb_copy_next;
        bit_index   <= bit_index_next;
        clock_level <= clock_level_next;
        out_valid   <= 1'b1;
      end else if (report.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      report.chip_select_n <= cs_n_now;
      report.serial_clock  <= clock_level;
      report.dio_out       <= drive_now & dio_now;
      report.dio_drive     <= drive_now;
      report.result_valid  <= fin;
      report.result        <= (fin && !mis) ? msb_copy : '0;
      report.mismatch      <= mis;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(accept && out_valid && !report.ready))
    else $error("report overwritten while stalled");

  a_finish_to_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && fin) |=> (phase == PH_IDLE))
    else $error("sequencer not idle after conversion end");

  a_mismatch_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && report.mismatch) |-> (report.result == '0 && report.result_valid))
    else $error("mismatch report carries data");

  a_drive_selected: assert property (@(posedge clk) disable iff (rst)
    (out_valid && report.dio_drive) |-> !report.chip_select_n)
    else $error("pin driven with chip select high");

  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_index < BIT_IDX_W'(DATA_BITS))
    else $error("bit index out of range");

endmodule

// File: verif/serial_adc_read_sequencer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_adc_read_sequencer_top_test
// Drives pin-level ticks into the read sequencer and checks every report
// against a cycle-exact model of the command, settle and double-read frame.
// A directed table covers reset, the command bits, the zero half period, the
// shared bit between the two copies, busy starts and a disagreeing read;
// random conversions follow under random register settings and random idling
// on both channels.
// ----------------------------------------------------------------------------
module serial_adc_read_sequencer_top_test;
  import sadc_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_START_LO = 5'd1,
    PH_START_HI = 5'd2,
    PH_MODE_LO  = 5'd3,
    PH_MODE_HI  = 5'd4,
    PH_CHAN_LO  = 5'd5,
    PH_CHAN_HI  = 5'd6,
    PH_SETTLE   = 5'd7,
    PH_MSB_HI   = 5'd8,
    PH_MSB_LO   = 5'd9,
    PH_LSB_HI   = 5'd10,
    PH_LSB_LO   = 5'd11
  } seq_phase_t;

  typedef struct packed {
    logic  cs_n;
    logic  sclk;
    logic  dout;
    logic  drive;
    logic  rvalid;
    data_t res;
    logic  mis;
  } pin_report_t;

  typedef enum logic [1:0] {ROW_TICK, ROW_RUN, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {PIN_LOW, PIN_HIGH, PIN_BYTE, PIN_SKEW} pin_src_t;

  typedef struct packed {
    row_kind_t               kind;
    logic                    start;
    pin_src_t                pin;
    data_t                   target;
    logic [7:0]              reps;
    cfg_index_t              reg_index;
    logic [CFG_DATA_W-1:0]   reg_value;
    logic                    typed;
    pin_report_t             want;
  } stim_row_t;

  localparam pin_report_t SHOW_IDLE      = '{cs_n: 1'b1, default: '0};
  localparam pin_report_t SHOW_START_BIT = '{dout: 1'b1, drive: 1'b1, default: '0};

  localparam int N_ROWS = 23;
  localparam stim_row_t STIM_TABLE [N_ROWS] = '{
    '{ROW_TICK, 1'b0, PIN_LOW,  8'h00, 8'd1, CFG_HALF_PERIOD,  16'd0,     1'b1, SHOW_IDLE},
    '{ROW_TICK, 1'b0, PIN_HIGH, 8'h00, 8'd1, CFG_HALF_PERIOD,  16'd0,     1'b1, SHOW_IDLE},
    '{ROW_TICK, 1'b1, PIN_HIGH, 8'h00, 8'd1, CFG_HALF_PERIOD,  16'd0,     1'b1, SHOW_IDLE},
    '{ROW_TICK, 1'b0, PIN_HIGH, 8'h00, 8'd1, CFG_HALF_PERIOD,  16'd0,     1'b1,
      SHOW_START_BIT},
    '{ROW_RUN,  1'b1, PIN_HIGH, 8'h00, 8'd0, CFG_HALF_PERIOD,  16'd0,     1'b0, SHOW_IDLE},
    '{ROW_TICK, 1'b0, PIN_LOW,  8'h00, 8'd3, CFG_HALF_PERIOD,  16'd0,     1'b1, SHOW_IDLE},
    '{ROW_CFG,  1'b0, PIN_LOW,  8'h00, 8'd0, CFG_HALF_PERIOD,  16'd0,     1'b0, SHOW_IDLE},
    '{ROW_CFG,  1'b0, PIN_LOW,  8'h00, 8'd0, CFG_SINGLE_ENDED, 16'd0,     1'b0, SHOW_IDLE},
    '{ROW_CFG,  1'b0, PIN_LOW,  8'h00, 8'd0, CFG_ODD_SELECT,   16'd1,     1'b0, SHOW_IDLE},
    '{ROW_TICK, 1'b1, PIN_LOW,  8'h00, 8'd1, CFG_HALF_PERIOD,  16'd0,     1'b1, SHOW_IDLE},
    '{ROW_RUN,  1'b0, PIN_LOW,  8'h00, 8'd0, CFG_HALF_PERIOD,  16'd0,     1'b0, SHOW_IDLE},
    '{ROW_CFG,  1'b0, PIN_LOW,  8'h00, 8'd0, CFG_HALF_PERIOD,  16'd1,     1'b0, SHOW_IDLE},
    '{ROW_TICK, 1'b1, PIN_BYTE, 8'h01, 8'd1, CFG_HALF_PERIOD,  16'd0,     1'b1, SHOW_IDLE},
    '{ROW_RUN,  1'b0, PIN_BYTE, 8'h01, 8'd0, CFG_HALF_PERIOD,  16'd0,     1'b0, SHOW_IDLE},
    '{ROW_TICK, 1'b1, PIN_BYTE, 8'hA5, 8'd1, CFG_HALF_PERIOD,  16'd0,     1'b1, SHOW_IDLE},
    '{ROW_RUN,  1'b0, PIN_BYTE, 8'hA5, 8'd0, CFG_HALF_PERIOD,  16'd0,     1'b0, SHOW_IDLE},
    '{ROW_CFG,  1'b0, PIN_LOW,  8'h00, 8'd0, CFG_HALF_PERIOD,  16'd3,     1'b0, SHOW_IDLE},
    '{ROW_CFG,  1'b0, PIN_LOW,  8'h00, 8'd0, CFG_ODD_SELECT,   16'd0,     1'b0, SHOW_IDLE},
    '{ROW_TICK, 1'b1, PIN_SKEW, 8'h81, 8'd1, CFG_HALF_PERIOD,  16'd0,     1'b1, SHOW_IDLE},
    '{ROW_RUN,  1'b0, PIN_SKEW, 8'h81, 8'd0, CFG_HALF_PERIOD,  16'd0,     1'b0, SHOW_IDLE},
    '{ROW_CFG,  1'b0, PIN_LOW,  8'h00, 8'd0, CFG_HALF_PERIOD,  16'd65535, 1'b0, SHOW_IDLE},
    '{ROW_TICK, 1'b0, PIN_HIGH, 8'h00, 8'd4, CFG_HALF_PERIOD,  16'd0,     1'b1, SHOW_IDLE},
    '{ROW_CFG,  1'b0, PIN_LOW,  8'h00, 8'd0, CFG_SINGLE_ENDED, 16'd1,     1'b0, SHOW_IDLE}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  cfg_index_t            cfg_index = CFG_HALF_PERIOD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  tick_valid = 1'b0;
  logic                  tick_start = 1'b0;
  logic                  tick_dio = 1'b0;
  logic                  accept_report = 1'b0;
  int unsigned           stall_left = 0;
  bit                    steady = 1'b0;

  // sequencer model state and its copy of the registers
  logic [TIMER_W-1:0]   half_period_q = HALF_PERIOD_RESET;
  logic                 single_ended_q = 1'b1;
  logic                 odd_select_q = 1'b0;
  seq_phase_t           seq_ph = PH_IDLE;
  logic [TIMER_W-1:0]   slot_timer = '0;
  data_t                msb_word = '0;
  data_t                lsb_word = '0;
  logic [BIT_IDX_W-1:0] bit_pos = '0;
  logic                 sclk_level = 1'b0;

  pin_report_t pending_reports [$];
  int unsigned errors = 0;
  int unsigned reports_seen = 0;
  int unsigned conversions_seen = 0;
  int unsigned disagreements_seen = 0;

  sadc_tick_if   tick_ch ();
  sadc_report_if report_ch ();

  assign tick_ch.valid     = tick_valid;
  assign tick_ch.start_req = tick_start;
  assign tick_ch.dio_in    = tick_dio;
  assign report_ch.ready   = accept_report;

  serial_adc_read_sequencer_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .report    (report_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic pin_report_t advance_sequencer(input logic start, input logic din);
    pin_report_t r;
    int unsigned span;
    seq_phase_t  nxt;
    r = '0;
    span = (half_period_q == '0) ? 1 : int'(half_period_q);
    r.cs_n = (seq_ph == PH_IDLE);
    r.sclk = sclk_level;
    r.drive = (seq_ph >= PH_START_LO && seq_ph <= PH_CHAN_HI);
    case (seq_ph)
      PH_START_LO, PH_START_HI: r.dout = 1'b1;
      PH_MODE_LO, PH_MODE_HI:   r.dout = single_ended_q;
      PH_CHAN_LO, PH_CHAN_HI:   r.dout = odd_select_q;
      default:                  r.dout = 1'b0;
    endcase
    if (seq_ph == PH_IDLE) begin
      if (start) begin
        seq_ph = PH_START_LO;
        slot_timer = '0;
        msb_word = '0;
        lsb_word = '0;
        bit_pos = '0;
      end
    end else if (seq_ph > PH_LSB_LO) begin
      seq_ph = PH_IDLE;
      slot_timer = '0;
    end else if (int'(slot_timer) + 1 < span) begin
      slot_timer = slot_timer + TIMER_W'(1);
    end else begin
      slot_timer = '0;
      nxt = seq_phase_t'(seq_ph + 5'd1);
      if (seq_ph == PH_MSB_LO) begin
        msb_word = {msb_word[DATA_BITS-2:0], din};
        if (int'(bit_pos) >= DATA_BITS - 1) begin
          // last MSB-first sample doubles as bit 0 of the LSB-first copy
          lsb_word = data_t'(din);
          bit_pos = '0;
          nxt = PH_LSB_HI;
        end else begin
          bit_pos = bit_pos + BIT_IDX_W'(1);
          nxt = PH_MSB_HI;
        end
      end else if (seq_ph == PH_LSB_LO) begin
        if (int'(bit_pos) >= DATA_BITS - 1) begin
          r.rvalid = 1'b1;
          r.mis = (msb_word != lsb_word);
          r.res = r.mis ? '0 : msb_word;
          bit_pos = '0;
          nxt = PH_IDLE;
        end else begin
          bit_pos = bit_pos + BIT_IDX_W'(1);
          lsb_word = lsb_word | (data_t'(din) << bit_pos[2:0]);
          nxt = PH_LSB_HI;
        end
      end
      seq_ph = nxt;
    end
    sclk_level = (seq_ph == PH_START_HI || seq_ph == PH_MODE_HI || seq_ph == PH_CHAN_HI ||
                  seq_ph == PH_MSB_HI || seq_ph == PH_LSB_HI);
    return r;
  endfunction

  // data pin level for src; with PIN_BYTE both copies read back as target
  function automatic logic pick_level(input pin_src_t src, input data_t target);
    logic lvl;
    lvl = 1'($urandom_range(0, 1));
    if (src == PIN_LOW)
      lvl = 1'b0;
    else if (src == PIN_HIGH)
      lvl = 1'b1;
    else if (seq_ph == PH_MSB_LO)
      lvl = target[DATA_BITS - 1 - int'(bit_pos)];
    else if (seq_ph == PH_LSB_LO && int'(bit_pos) < DATA_BITS - 1)
      lvl = target[int'(bit_pos) + 1] ^ (src == PIN_SKEW);
    return lvl;
  endfunction

  task automatic send_tick(input logic start, input logic level, input logic typed,
                           input pin_report_t want);
    pin_report_t got;
    if (!steady && $urandom_range(0, 9) == 0) begin
      tick_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick_start <= start;
    tick_dio <= level;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    got = advance_sequencer(start, level);
    pending_reports.push_back(typed ? want : got);
  endtask

  task automatic drain_reports();
    tick_valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_HALF_PERIOD:  half_period_q = val;
      CFG_SINGLE_ENDED: single_ended_q = val[0];
      CFG_ODD_SELECT:   odd_select_q = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      if (errors < 10)
        $display("MISMATCH %s on report %0d: expected %0h, got %0h",
                 name, reports_seen, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (steady) begin
      accept_report <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      accept_report <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 11) == 0) begin
      accept_report <= 1'b0;
      stall_left <= $urandom_range(0, 10);
    end else begin
      accept_report <= 1'b1;
    end
  end

  always @(posedge clk) begin : report_check
    pin_report_t want;
    if (!rst && report_ch.valid === 1'b1 && report_ch.ready === 1'b1) begin
      if (pending_reports.size() == 0) begin
        if (errors < 10)
          $display("MISMATCH report %0d transferred with nothing pending", reports_seen);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        check_field("chip_select_n", 8'(want.cs_n), 8'(report_ch.chip_select_n));
        check_field("serial_clock", 8'(want.sclk), 8'(report_ch.serial_clock));
        check_field("dio_out", 8'(want.dout), 8'(report_ch.dio_out));
        check_field("dio_drive", 8'(want.drive), 8'(report_ch.dio_drive));
        check_field("result_valid", 8'(want.rvalid), 8'(report_ch.result_valid));
        check_field("result", want.res, report_ch.result);
        check_field("mismatch", 8'(want.mis), 8'(report_ch.mismatch));
        if (report_ch.result_valid === 1'b1) begin
          conversions_seen++;
          if (report_ch.mismatch === 1'b1) disagreements_seen++;
        end
      end
      reports_seen++;
    end
  end

  initial begin : stimulus
    stim_row_t   row;
    data_t       target;
    logic        lvl;
    int unsigned style;
    int unsigned span;
    int unsigned pick;
    int unsigned n_conv;
    int unsigned segment;
    int unsigned conv_ticks;
    segment = 0;
    conv_ticks = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_ROWS; i++) begin
      row = STIM_TABLE[i];
      case (row.kind)
        ROW_CFG: begin
          drain_reports();
          write_reg(row.reg_index, row.reg_value);
        end
        ROW_TICK: begin
          repeat (row.reps)
            send_tick(row.start, pick_level(row.pin, row.target), row.typed, row.want);
        end
        default: begin
          while (seq_ph != PH_IDLE)
            send_tick(row.start, pick_level(row.pin, row.target), 1'b0, SHOW_IDLE);
        end
      endcase
    end

    while (conv_ticks < 1000 || !steady) begin
      steady = (conv_ticks >= 850);
      drain_reports();
      pick = $urandom_range(0, 99);
      if (segment == 3)
        span = 10;
      else if (pick < 8)
        span = 0;
      else if (pick < 50)
        span = 1;
      else if (pick < 75)
        span = 2;
      else if (pick < 90)
        span = $urandom_range(3, 4);
      else
        span = $urandom_range(5, 9);
      write_reg(CFG_HALF_PERIOD, CFG_DATA_W'(span));
      write_reg(CFG_SINGLE_ENDED, CFG_DATA_W'($urandom_range(0, 1)));
      write_reg(CFG_ODD_SELECT, CFG_DATA_W'($urandom_range(0, 1)));
      n_conv = (segment == 3) ? 1 : $urandom_range(2, 4);
      for (int c = 0; c < n_conv; c++) begin
        if (!steady && $urandom_range(0, 7) == 0) drain_reports();
        repeat ($urandom_range(0, 3))
          send_tick(1'b0, 1'($urandom_range(0, 1)), 1'b0, SHOW_IDLE);
        target = data_t'($urandom);
        style = $urandom_range(0, 9);
        send_tick(1'b1, 1'($urandom_range(0, 1)), 1'b0, SHOW_IDLE);
        conv_ticks++;
        while (seq_ph != PH_IDLE) begin
          lvl = pick_level(PIN_BYTE, target);
          // flip the odd sample, or scramble the whole read
          if (style == 9)
            lvl = 1'($urandom_range(0, 1));
          else if (style >= 7 && $urandom_range(0, 7) == 0)
            lvl = ~lvl;
          send_tick($urandom_range(0, 3) == 0, lvl, 1'b0, SHOW_IDLE);
          conv_ticks++;
        end
      end
      segment++;
    end

    drain_reports();
    repeat (4) @(posedge clk);
    $display("Checked %0d reports over %0d conversions, %0d of them with disagreeing copies.",
             reports_seen, conversions_seen, disagreements_seen);
    $display("Half periods from 0 to 65535, both modes, both channels, busy starts included.");
    if (errors == 0 && pending_reports.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
